// ===== design/eeuc_pkg.sv =====
// Shared constants, types and helpers for the EUC-KR string escape encoder.
package eeuc_pkg;

  localparam int MAX_IN_LEN  = 4096;
  localparam int OUT_CAP_RAW = 2 * MAX_IN_LEN;
  localparam int OUT_CAP     = (OUT_CAP_RAW > 16383) ? 16383 : OUT_CAP_RAW;
  localparam int LEN_W       = 14;
  localparam int GRP_N       = 3;

  localparam logic [7:0] PAIR_LO   = 8'hA1;
  localparam logic [7:0] PAIR_HI   = 8'hFE;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;

  typedef struct packed {
    logic [1:0]             cnt;
    logic [GRP_N-1:0][7:0]  bytes;
    logic                   last;
    logic                   err;
    logic [LEN_W-1:0]       len;
  } grp_t;

  function automatic logic in_pair_range(input logic [7:0] b);
    in_pair_range = (b >= PAIR_LO) && (b <= PAIR_HI);
  endfunction

endpackage

// ===== design/eeuc_ifs.sv =====
// Valid/ready stream interfaces for the request and result channels.
interface eeuc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface eeuc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        error_flag;
  logic [13:0] out_length;

  modport source (output valid, output out_byte, output out_last, output error_flag,
                  output out_length, input ready);
  modport sink (input valid, input out_byte, input out_last, input error_flag,
                input out_length, output ready);
endinterface

// ===== design/eeuc_core.sv =====
// Per-string state and the escape decision that turns one request into a result group.
module eeuc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output eeuc_pkg::grp_t grp
);
  import eeuc_pkg::*;

  logic             held_valid_r, held_valid_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             discarding_r, discarding_nxt;

  logic [7:0]       e0, e1;
  logic [1:0]       ecnt;
  logic [LEN_W:0]   sum;
  logic [LEN_W-1:0] sat;
  logic             is_pair, is_reject;

  always_comb begin
    is_pair   = in_pair_range(in_byte);
    is_reject = (in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE) || (in_byte == CH_TAB);

    case (in_byte)
      CH_NL: begin
        e0 = CH_BSLASH; e1 = CH_N; ecnt = 2'd2;
      end
      CH_CR: begin
        e0 = CH_BSLASH; e1 = CH_R; ecnt = 2'd2;
      end
      CH_BSLASH: begin
        e0 = CH_BSLASH; e1 = CH_BSLASH; ecnt = 2'd2;
      end
      default: begin
        e0 = in_byte; e1 = 8'h00; ecnt = 2'd1;
      end
    endcase

    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    discarding_nxt = discarding_r;
    grp.cnt   = 2'd0;
    grp.bytes = '0;
    grp.last  = 1'b0;
    grp.err   = 1'b0;
    grp.len   = '0;

    if (discarding_r) begin
      if (in_last) begin
        discarding_nxt = 1'b0;
        held_valid_nxt = 1'b0;
      end
    end else if (held_valid_r && is_pair) begin
      held_valid_nxt = 1'b0;
      grp.cnt   = 2'd2;
      grp.bytes = {8'h00, in_byte, held_byte_r};
    end else if (is_reject) begin
      held_valid_nxt = 1'b0;
      discarding_nxt = !in_last;
      grp.cnt  = 2'd1;
      grp.err  = 1'b1;
      grp.last = 1'b1;
    end else begin
      held_valid_nxt = 1'b0;
      if (is_pair && !in_last) begin
        held_valid_nxt = 1'b1;
        held_byte_nxt  = in_byte;
        grp.cnt   = {1'b0, held_valid_r};
        grp.bytes = {16'h0000, held_byte_r};
      end else if (held_valid_r) begin
        grp.cnt   = ecnt + 2'd1;
        grp.bytes = {e1, e0, held_byte_r};
      end else begin
        grp.cnt   = ecnt;
        grp.bytes = {8'h00, e1, e0};
      end
    end

    sum = {1'b0, count_r} + {{(LEN_W - 1){1'b0}}, grp.cnt};
    sat = (sum > (LEN_W + 1)'(OUT_CAP)) ? LEN_W'(OUT_CAP) : sum[LEN_W-1:0];
    count_nxt = sat;

    if (grp.err || (discarding_r && in_last)) begin
      count_nxt = '0;
    end else if (!discarding_r && in_last) begin
      grp.last  = (grp.cnt != 2'd0);
      grp.len   = sat;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      count_r      <= '0;
      discarding_r <= 1'b0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
      count_r      <= count_nxt;
      discarding_r <= discarding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte_r <= held_byte_nxt;
    end
  end

endmodule

// ===== design/eeuc_obuf.sv =====
// Result register that holds one result group and sends its entries one per cycle while out_ready is high.
module eeuc_obuf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  eeuc_pkg::grp_t               grp,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         error_flag,
  output logic [eeuc_pkg::LEN_W-1:0]   out_length,
  output logic                         in_ready
);
  import eeuc_pkg::*;

  grp_t       grp_r;
  logic [1:0] rem_r, rem_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       take;
  logic       final_entry;

  always_comb begin
    out_valid   = (rem_r != 2'd0);
    take        = out_valid && out_ready;
    final_entry = (rem_r == 2'd1);
    in_ready    = (rem_r == 2'd0) || (final_entry && out_ready);

    case (pos_r)
      2'd0:    out_byte = grp_r.bytes[0];
      2'd1:    out_byte = grp_r.bytes[1];
      2'd2:    out_byte = grp_r.bytes[2];
      default: out_byte = 8'h00;
    endcase
    out_last   = grp_r.last && final_entry;
    error_flag = grp_r.err;
    out_length = (grp_r.last && final_entry) ? grp_r.len : '0;

    rem_nxt = rem_r;
    pos_nxt = pos_r;
    if (load) begin
      rem_nxt = grp.cnt;
      pos_nxt = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 2'd1;
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      pos_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

  // A new group may only land when the current one is gone or leaving.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((rem_r == 2'd0) || (final_entry && out_ready)))
    else $error("result group overwritten before it was sent");

  // An error result always stands alone and closes the string.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && error_flag) |-> out_last)
    else $error("error result is not the final result");

  // The read position never runs past the three group entries.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, pos_r} + {1'b0, rem_r}) <= 3'd3))
    else $error("result position out of range");

  // After the final result is taken with nothing loaded, the buffer is empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_last && !load) |=> (rem_r == 2'd0))
    else $error("results remain after the final result");

endmodule

// ===== design/escape_encoder_euc_kr.sv =====
// Streaming escape encoder for EUC-KR strings: one source byte in, escaped bytes out.
// Latency: the first result of a request is offered in the cycle after the request.
// Throughput: one request per cycle while each request yields at most one result and the
// result channel is ready; a request with more results occupies the result register until
// its final result leaves, and the next request is taken in the cycle that it leaves.
// Reset: synchronous active-low rst_n clears the held lead byte, the length count,
// the discard state and the result register.
module escape_encoder_euc_kr (
  input  logic       clk,
  input  logic       rst_n,
  eeuc_in_if.sink    in_ch,
  eeuc_out_if.source out_ch
);
  import eeuc_pkg::*;

  grp_t grp;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;

  eeuc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .grp     (grp)
  );

  eeuc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .grp        (grp),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.out_last),
    .error_flag (out_ch.error_flag),
    .out_length (out_ch.out_length),
    .in_ready   (in_ch.ready)
  );

endmodule
